// ===== rtl/core/tsq_pkg.sv =====
// Package for the temperature sample qualifier: register map codes, reset
// values and the small arithmetic helpers used by the qualifier datapath.
// No dependencies.
package tsq_pkg;

   typedef logic signed [11:0] temp_type;

   // Register indexes on the configuration port (byte address is 4 * index).
   typedef enum logic [2:0] {
      CSR_MIN_TEMP     = 3'd0,
      CSR_MAX_TEMP     = 3'd1,
      CSR_MAX_STEP     = 3'd2,
      CSR_REBASE       = 3'd3,
      CSR_STALE_TIMEOUT = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_ADDR_BITS = 5;

   localparam logic [11:0] MIN_TEMP_RESET      = 12'hEC0;   // -320
   localparam logic [11:0] MAX_TEMP_RESET      = 12'd680;
   localparam logic [10:0] MAX_STEP_RESET      = 11'd40;
   localparam logic [7:0]  REBASE_RESET        = 8'd3;
   localparam logic [31:0] STALE_TIMEOUT_RESET = 32'd500000;

   // The raw sensor value is offset by 23 degrees, in eighths.
   localparam temp_type TEMP_OFFSET_EIGHTHS = 12'sd184;

   typedef enum logic {
      ACTION_SAMPLE = 1'b0,
      ACTION_QUERY  = 1'b1
   } action_type;

   // Result fields as they travel through the output register.
   typedef struct packed {
      logic [11:0] temperature_eighths;
      logic        temp_fresh;
      logic        latched_valid;
      logic [31:0] age_us;
      logic [31:0] outlier_count;
   } rsp_type;

   // Unpacks the two sensor bytes into eighths of a degree.
   function automatic temp_type unpack_temp(input logic [7:0] msb, input logic [7:0] lsb);
      logic [10:0] raw;
      begin
         raw = {msb, lsb[7:5]};
         return $signed({raw[10], raw}) + TEMP_OFFSET_EIGHTHS;
      end
   endfunction

   // True when the two temperatures differ by more than the allowed step.
   function automatic logic too_far(input temp_type a, input temp_type b,
                                    input logic [10:0] step);
      logic signed [12:0] diff;
      logic [12:0]        mag;
      begin
         diff = {a[11], a} - {b[11], b};
         mag  = diff[12] ? 13'(-diff) : 13'(diff);
         return mag > {2'b00, step};
      end
   endfunction

endpackage

// ===== rtl/core/temperature_sample_qualifier_top.sv =====
// An accepted request beat passes the input register, then the result register,
// to its response beat. Throughput: one item per cycle unless a held response is stalled.
// The output register is loaded whenever it is empty or being drained, so a
// held response does not block the input while the downstream side takes it.
// Reset (synchronous, active high) restores the register defaults and clears
// the held temperature, validity, run and counters. Depends on tsq_pkg.
module temperature_sample_qualifier_top #(
   parameter int unsigned TIMESTAMP_BITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [7:0]                            req_temp_msb,
   input  logic [7:0]                            req_temp_lsb,
   input  logic [63:0]                           req_now_us,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [11:0]                    rsp_temperature_eighths,
   output logic                                  rsp_temp_fresh,
   output logic                                  rsp_latched_valid,
   output logic [31:0]                           rsp_age_us,
   output logic [31:0]                           rsp_outlier_count,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tsq_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   // Configuration registers.
   logic [11:0] min_temp_ff;
   logic [11:0] max_temp_ff;
   logic [10:0] max_step_ff;
   logic [7:0]  rebase_ff;
   logic [31:0] timeout_ff;

   // Input register.
   logic                      s1_valid_ff;
   logic                      action_ff;
   logic [7:0]                msb_ff;
   logic [7:0]                lsb_ff;
   logic [TIMESTAMP_BITS-1:0] now_ff;

   // Qualifier state.
   tsq_pkg::temp_type         held_temp_ff,  held_temp_in;
   logic                      valid_flag_ff, valid_flag_in;
   logic [TIMESTAMP_BITS-1:0] last_time_ff,  last_time_in;
   tsq_pkg::temp_type         cand_ff,       cand_in;
   logic [7:0]                count_ff,      count_in;
   logic [31:0]               outliers_ff,   outliers_in;

   // Output register.
   logic              rsp_valid_ff;
   tsq_pkg::rsp_type  rsp_ff, rsp_in;

   logic                      advance;
   logic                      csr_write;
   tsq_pkg::csr_index_type    csr_idx;
   tsq_pkg::temp_type         sample_t;
   logic                      updated;
   logic                      behind;
   logic [TIMESTAMP_BITS-1:0] diff;
   logic [63:0]               diff_ext;
   logic [7:0]                run_count;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_idx   = tsq_pkg::csr_index_type'(paddr[tsq_pkg::CSR_ADDR_BITS-1:2]);

   always_comb begin
      unique case (csr_idx)
         tsq_pkg::CSR_MIN_TEMP:      prdata = {20'd0, min_temp_ff};
         tsq_pkg::CSR_MAX_TEMP:      prdata = {20'd0, max_temp_ff};
         tsq_pkg::CSR_MAX_STEP:      prdata = {21'd0, max_step_ff};
         tsq_pkg::CSR_REBASE:        prdata = {24'd0, rebase_ff};
         tsq_pkg::CSR_STALE_TIMEOUT: prdata = timeout_ff;
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff <= tsq_pkg::MIN_TEMP_RESET;
         max_temp_ff <= tsq_pkg::MAX_TEMP_RESET;
         max_step_ff <= tsq_pkg::MAX_STEP_RESET;
         rebase_ff   <= tsq_pkg::REBASE_RESET;
         timeout_ff  <= tsq_pkg::STALE_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            tsq_pkg::CSR_MIN_TEMP:      min_temp_ff <= pwdata[11:0];
            tsq_pkg::CSR_MAX_TEMP:      max_temp_ff <= pwdata[11:0];
            tsq_pkg::CSR_MAX_STEP:      max_step_ff <= pwdata[10:0];
            tsq_pkg::CSR_REBASE:        rebase_ff   <= pwdata[7:0];
            tsq_pkg::CSR_STALE_TIMEOUT: timeout_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   // The input register moves forward whenever the output register can load.
   assign advance   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid & ~req_stall) begin
         action_ff <= req_action;
         msb_ff    <= req_temp_msb;
         lsb_ff    <= req_temp_lsb;
         now_ff    <= req_now_us[TIMESTAMP_BITS-1:0];
      end
   end

   assign sample_t = tsq_pkg::unpack_temp(msb_ff, lsb_ff);

   // Sample qualification and the recovery run.
   always_comb begin
      held_temp_in  = held_temp_ff;
      valid_flag_in = valid_flag_ff;
      last_time_in  = last_time_ff;
      cand_in       = cand_ff;
      count_in      = count_ff;
      outliers_in   = outliers_ff;
      updated       = 1'b0;
      run_count     = 8'd0;
      if (tsq_pkg::action_type'(action_ff) == tsq_pkg::ACTION_SAMPLE) begin
         if (sample_t < $signed(min_temp_ff) || sample_t > $signed(max_temp_ff) ||
             (valid_flag_ff && tsq_pkg::too_far(sample_t, held_temp_ff, max_step_ff))) begin
            outliers_in   = outliers_ff + 32'd1;
            valid_flag_in = 1'b0;
            count_in      = 8'd0;
         end else if (valid_flag_ff) begin
            held_temp_in = sample_t;
            last_time_in = now_ff;
            updated      = 1'b1;
         end else begin
            if (count_ff == 8'd0 || tsq_pkg::too_far(sample_t, cand_ff, max_step_ff)) begin
               run_count = 8'd1;
            end else begin
               run_count = count_ff + 8'd1;
            end
            cand_in  = sample_t;
            count_in = run_count;
            if (run_count >= rebase_ff) begin
               held_temp_in  = sample_t;
               last_time_in  = now_ff;
               count_in      = 8'd0;
               valid_flag_in = 1'b1;
               updated       = 1'b1;
            end
         end
      end
   end

   // Age is measured against the stored time; a fresh accept has age zero.
   assign behind   = now_ff < last_time_ff;
   assign diff     = now_ff - last_time_ff;
   assign diff_ext = 64'(diff);

   always_comb begin
      rsp_in.temperature_eighths = held_temp_in;
      rsp_in.latched_valid       = valid_flag_in;
      rsp_in.outlier_count       = outliers_in;
      rsp_in.age_us              = 32'd0;
      rsp_in.temp_fresh          = 1'b0;
      if (valid_flag_in) begin
         if (updated) begin
            rsp_in.temp_fresh = 1'b1;
         end else if (behind) begin
            rsp_in.age_us = '1;
         end else begin
            rsp_in.temp_fresh = diff_ext <= {32'd0, timeout_ff};
            rsp_in.age_us     = (|diff_ext[63:32]) ? '1 : diff_ext[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_temp_ff  <= '0;
         valid_flag_ff <= 1'b0;
         last_time_ff  <= '0;
         cand_ff       <= '0;
         count_ff      <= 8'd0;
         outliers_ff   <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            held_temp_ff  <= held_temp_in;
            valid_flag_ff <= valid_flag_in;
            last_time_ff  <= last_time_in;
            cand_ff       <= cand_in;
            count_ff      <= count_in;
            outliers_ff   <= outliers_in;
            rsp_valid_ff  <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_temperature_eighths = $signed(rsp_ff.temperature_eighths);
   assign rsp_temp_fresh          = rsp_ff.temp_fresh;
   assign rsp_latched_valid       = rsp_ff.latched_valid;
   assign rsp_age_us              = rsp_ff.age_us;
   assign rsp_outlier_count       = rsp_ff.outlier_count;

endmodule
